FILE: src/huffman_tree_byte_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tree-walk byte decoder
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_BYTE_DECODER_ASSERT_SVH
`define HUFFMAN_TREE_BYTE_DECODER_ASSERT_SVH

// Same-cycle implication.
`define HBD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define HBD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/hbd_pkg.sv
// ----------------------------------------------------------------------------
// hbd_pkg
// Shared types and constants of the tree-walk byte decoder.
// ----------------------------------------------------------------------------
package hbd_pkg;

    localparam int REQ_W   = 2;
    localparam int NODE_W  = 9;
    localparam int COUNT_W = 32;
    localparam int CODE_W  = 8;
    localparam int SYM_W   = 8;
    localparam int ROW_W   = 12;
    localparam int POS_W   = 13;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_START = 2'd1;
    localparam logic [REQ_W-1:0] REQ_BYTE  = 2'd2;

    localparam logic [ROW_W-1:0] ROW_WIDTH_RESET = 12'd240;

    localparam int QUEUE_DEPTH = 2;

    // one queued word, already classified
    typedef struct packed {
        logic [REQ_W-1:0]   op;
        logic [NODE_W-1:0]  node;
        logic [NODE_W-1:0]  left;
        logic [NODE_W-1:0]  right;
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  code;
    } item_t;

    // one result word
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             line_end;
        logic             done_res;
        logic             last;
    } res_t;

endpackage

FILE: src/hbd_front.sv
// ----------------------------------------------------------------------------
// hbd_front
// Accepts input words, drops the ones with no effect, queues the rest.
// ----------------------------------------------------------------------------
module hbd_front
    import hbd_pkg::*;
#(
    parameter int SYMBOL_COUNT_MAX = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [NODE_W-1:0]  node_index,
    input  logic [NODE_W-1:0]  left_child,
    input  logic [NODE_W-1:0]  right_child,
    input  logic [COUNT_W-1:0] symbol_count,
    input  logic [CODE_W-1:0]  code_byte,
    output logic               head_valid,
    input  logic               head_ready,
    output item_t              head
);

    localparam logic [NODE_W-1:0] LEAF_MAX = NODE_W'(SYMBOL_COUNT_MAX);
    localparam logic [NODE_W-1:0] ROOT     = NODE_W'(2 * SYMBOL_COUNT_MAX - 1);
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              keep;
    logic              push;
    logic              pop;
    item_t             in_item;

    // keep loads into internal nodes, starts and code bytes; drop the rest
    always_comb
    begin
        keep = 1'b0;
        unique case (req_type)
            REQ_LOAD:  keep = (node_index > LEAF_MAX) && (node_index <= ROOT);
            REQ_START: keep = 1'b1;
            REQ_BYTE:  keep = 1'b1;
            default:   keep = 1'b0;
        endcase
    end

    assign in_item.op    = req_type;
    assign in_item.node  = node_index;
    assign in_item.left  = left_child;
    assign in_item.right = right_child;
    assign in_item.count = symbol_count;
    assign in_item.code  = code_byte;

    assign in_ready   = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready && keep;
    assign head_valid = (cnt_reg != '0);
    assign pop        = head_valid && head_ready;
    assign head       = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: src/hbd_back.sv
// ----------------------------------------------------------------------------
// hbd_back
// Executes queued words: table writes, starts and the bit-serial tree walk.
// ----------------------------------------------------------------------------
module hbd_back
    import hbd_pkg::*;
#(
    parameter int SYMBOL_COUNT_MAX = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [ROW_W-1:0]   cfg_wr_data,
    input  logic               head_valid,
    output logic               head_ready,
    input  item_t              head,
    output logic               out_valid,
    input  logic               out_ready,
    output res_t               out_res
);

`include "huffman_tree_byte_decoder_assert.svh"

    localparam logic [NODE_W-1:0] LEAF_MAX = NODE_W'(SYMBOL_COUNT_MAX);
    localparam logic [NODE_W-1:0] ROOT     = NODE_W'(2 * SYMBOL_COUNT_MAX - 1);
    localparam int SLOT_W = $clog2(SYMBOL_COUNT_MAX);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [2*NODE_W-1:0] tbl_mem [SYMBOL_COUNT_MAX];
    logic [2*NODE_W-1:0] rd_data_reg;
    logic                tbl_vld_reg, tbl_vld_next;

    logic [1:0]          state_reg, state_next;
    logic [2:0]          bit_idx_reg, bit_idx_next;
    logic [CODE_W-1:0]   byte_reg, byte_next;
    logic [NODE_W-1:0]   node_reg, node_next;
    logic [COUNT_W-1:0]  left_cnt_reg, left_cnt_next;
    logic [POS_W-1:0]    row_pos_reg, row_pos_next;
    logic [ROW_W-1:0]    row_width_reg;
    logic                pend_valid_reg, pend_valid_next;
    res_t                pend_reg, pend_next;
    logic                out_valid_reg;
    res_t                out_reg;

    logic                wr_en;
    logic                out_free;
    logic                out_push;
    res_t                out_data;
    logic                cur_bit;
    logic [NODE_W-1:0]   child;
    logic [NODE_W-1:0]   child_m1;
    logic                is_leaf;
    logic                is_inner;
    logic                byte_end;
    logic                count_hit;
    logic [POS_W-1:0]    row_inc;
    logic [POS_W-1:0]    row_limit;
    logic                row_hit;
    logic [NODE_W-1:0]   rd_sub;
    logic [NODE_W-1:0]   wr_sub;

    assign out_free  = !out_valid_reg || out_ready;
    assign cur_bit   = byte_reg[~bit_idx_reg];
    assign child     = cur_bit ? rd_data_reg[NODE_W-1:0] : rd_data_reg[2*NODE_W-1:NODE_W];
    assign child_m1  = child - NODE_W'(1);
    assign is_leaf   = (child != '0) && (child <= LEAF_MAX);
    assign is_inner  = (child > LEAF_MAX) && (child <= ROOT);
    assign byte_end  = (bit_idx_reg == 3'd7);
    assign count_hit = (left_cnt_reg == COUNT_W'(1));
    assign row_inc   = row_pos_reg + POS_W'(1);
    assign row_limit = {row_width_reg, 1'b0};
    assign row_hit   = (row_inc >= row_limit);

    always_comb
    begin
        state_next      = state_reg;
        bit_idx_next    = bit_idx_reg;
        byte_next       = byte_reg;
        node_next       = node_reg;
        left_cnt_next   = left_cnt_reg;
        row_pos_next    = row_pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        head_ready      = 1'b0;
        wr_en           = 1'b0;
        out_push        = 1'b0;
        out_data        = pend_reg;
        out_data.last   = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head.op)
                        REQ_LOAD:
                        begin
                            wr_en      = 1'b1;
                            head_ready = 1'b1;
                        end
                        REQ_START:
                        begin
                            left_cnt_next = head.count;
                            node_next     = ROOT;
                            row_pos_next  = '0;
                            head_ready    = 1'b1;
                        end
                        REQ_BYTE:
                        begin
                            // drop bytes past the count; wait for fresh table data
                            if (left_cnt_reg == '0)
                            begin
                                head_ready = 1'b1;
                            end
                            else if (tbl_vld_reg)
                            begin
                                head_ready   = 1'b1;
                                byte_next    = head.code;
                                bit_idx_next = '0;
                                state_next   = ST_WALK;
                            end
                        end
                        default:
                        begin
                            head_ready = 1'b1;
                        end
                    endcase
                end
            end

            ST_WALK:
            begin
                if (is_leaf)
                begin
                    // hold the walk while the previous symbol cannot move out
                    if (!pend_valid_reg || out_free)
                    begin
                        out_push           = pend_valid_reg;
                        pend_valid_next    = 1'b1;
                        pend_next.symbol   = child_m1[SYM_W-1:0];
                        pend_next.line_end = row_hit;
                        pend_next.done_res = count_hit;
                        pend_next.last     = 1'b0;
                        node_next          = ROOT;
                        left_cnt_next      = left_cnt_reg - COUNT_W'(1);
                        row_pos_next       = row_hit ? '0 : row_inc;
                        if (count_hit || byte_end)
                        begin
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            bit_idx_next = bit_idx_reg + 3'd1;
                        end
                    end
                end
                else
                begin
                    if (is_inner)
                    begin
                        node_next = child;
                    end
                    if (byte_end)
                    begin
                        state_next = pend_valid_reg ? ST_FLUSH : ST_IDLE;
                    end
                    else
                    begin
                        bit_idx_next = bit_idx_reg + 3'd1;
                    end
                end
            end

            ST_FLUSH:
            begin
                // the held symbol is the final one of its byte
                if (out_free)
                begin
                    out_push        = 1'b1;
                    out_data.last   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // the read always fetches the children of the node the walk holds next
    assign rd_sub       = node_next - LEAF_MAX;
    assign wr_sub       = head.node - LEAF_MAX;
    assign tbl_vld_next = !wr_en;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[wr_sub[SLOT_W-1:0]] <= {head.left, head.right};
        end
        rd_data_reg <= tbl_mem[rd_sub[SLOT_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            bit_idx_reg    <= '0;
            node_reg       <= ROOT;
            left_cnt_reg   <= '0;
            row_pos_reg    <= '0;
            row_width_reg  <= ROW_WIDTH_RESET;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            tbl_vld_reg    <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bit_idx_reg    <= bit_idx_next;
            node_reg       <= node_next;
            left_cnt_reg   <= left_cnt_next;
            row_pos_reg    <= row_pos_next;
            pend_valid_reg <= pend_valid_next;
            tbl_vld_reg    <= tbl_vld_next;
            if (cfg_wr_en)
            begin
                row_width_reg <= cfg_wr_data;
            end
            if (out_push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        pend_reg <= pend_next;
        if (out_push)
        begin
            out_reg <= out_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    `HBD_ASSERT_NOW(a_walk_has_count, state_reg == ST_WALK, left_cnt_reg != '0,
        "walk running with no symbols left")
    `HBD_ASSERT_NOW(a_flush_has_symbol, state_reg == ST_FLUSH, pend_valid_reg,
        "flush entered with no held symbol")
    `HBD_ASSERT_NEXT(a_done_is_last, out_push && out_data.done_res,
        out_valid_reg && out_reg.last && left_cnt_reg == '0,
        "final symbol of the count not marked last")

endmodule

FILE: src/huffman_tree_byte_decoder.sv
// ----------------------------------------------------------------------------
// huffman_tree_byte_decoder
// Tree-walk decoder for 256 byte symbols with a line-end mark per image row.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | req_type node_index left_child right_child
//          |                      | symbol_count code_byte
//  out     | out_valid / out_ready| symbol line_end done_res last
//  cfg     | cfg_wr_en            | cfg_wr_data (row_width)
//
//  A code byte leaves the queue and then walks the tree with one table read
//  per bit, stopping early when the count runs out mid-byte; a flush state
//  then marks the last symbol when the byte produced any. A byte right after
//  a node load waits for the table read port to refresh. Loads and starts
//  are done from the idle state; the input queue holds two words.
//  Reset puts the walk at the root with no symbols left; the table is not
//  cleared. A stalled output fills the result register and one held symbol,
//  then holds the walk at the next leaf it reaches.
// ----------------------------------------------------------------------------
module huffman_tree_byte_decoder
    import hbd_pkg::*;
#(
    parameter int SYMBOL_COUNT_MAX = 256
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [ROW_W-1:0]   cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [REQ_W-1:0]   req_type,
    input  logic [NODE_W-1:0]  node_index,
    input  logic [NODE_W-1:0]  left_child,
    input  logic [NODE_W-1:0]  right_child,
    input  logic [COUNT_W-1:0] symbol_count,
    input  logic [CODE_W-1:0]  code_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [SYM_W-1:0]   symbol,
    output logic               line_end,
    output logic               done_res,
    output logic               last
);

    // queue head between the two halves
    logic  head_valid;
    logic  head_ready;
    item_t head;
    res_t  out_res;

    // accept, classify and queue words
    hbd_front #(
        .SYMBOL_COUNT_MAX (SYMBOL_COUNT_MAX)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .node_index   (node_index),
        .left_child   (left_child),
        .right_child  (right_child),
        .symbol_count (symbol_count),
        .code_byte    (code_byte),
        .head_valid   (head_valid),
        .head_ready   (head_ready),
        .head         (head)
    );

    // walk the tree and drive the result register
    hbd_back #(
        .SYMBOL_COUNT_MAX (SYMBOL_COUNT_MAX)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .head_valid  (head_valid),
        .head_ready  (head_ready),
        .head        (head),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_res     (out_res)
    );

    assign symbol   = out_res.symbol;
    assign line_end = out_res.line_end;
    assign done_res = out_res.done_res;
    assign last     = out_res.last;

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// Tree-walk byte decoder regression
// Loads small code trees, starts decode runs and streams code bytes through
// the block under random input gaps and output stalls. An in-order software
// walk of the same tree predicts the symbol words of plain rows; hand-written
// words replace it for the rows of the directed opening that carry them.
// ----------------------------------------------------------------------------
module testbench;
    import hbd_pkg::*;

    // request code the block must drop
    localparam logic [REQ_W-1:0]  REQ_UNUSED = 2'd3;
    // node numbering: leaves 1..256, internal 257..511, root 511
    localparam logic [NODE_W-1:0] LEAF_TOP   = 9'd256;
    localparam logic [NODE_W-1:0] ROOT_NODE  = 9'd511;
    // cycles to let a busy walk finish when no result marks its end
    localparam int SETTLE_CYCLES = 40;
    localparam int DIRECTED_N    = 30;
    localparam int RANDOM_ROUNDS = 23;

    // one stimulus step: a config write or an input word, with optional
    // hand-written expectation (at most one symbol word)
    typedef struct {
        bit                 is_cfg;
        logic [ROW_W-1:0]   width;
        logic [REQ_W-1:0]   op;
        logic [NODE_W-1:0]  node;
        logic [NODE_W-1:0]  left;
        logic [NODE_W-1:0]  right;
        logic [COUNT_W-1:0] count;
        logic [CODE_W-1:0]  code;
        bit                 typed;
        int                 n_typed;
        res_t               want;
    } step_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [ROW_W-1:0]   cfg_wr_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [REQ_W-1:0]   req_type = REQ_LOAD;
    logic [NODE_W-1:0]  node_index = '0;
    logic [NODE_W-1:0]  left_child = '0;
    logic [NODE_W-1:0]  right_child = '0;
    logic [COUNT_W-1:0] symbol_count = '0;
    logic [CODE_W-1:0]  code_byte = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [SYM_W-1:0]   symbol;
    logic               line_end;
    logic               done_res;
    logic               last;

    // tag that travels with the payload so the scoreboard knows which
    // accepted word carries a hand-written expectation
    bit                 word_typed = 1'b0;
    int                 word_n_typed = 0;
    res_t               word_want = '0;

    // decoder state as the scoreboard tracks it
    logic [NODE_W-1:0]  tree_left  [256];
    logic [NODE_W-1:0]  tree_right [256];
    logic [NODE_W-1:0]  walk_node = ROOT_NODE;
    logic [COUNT_W-1:0] syms_left_m = '0;
    logic [POS_W-1:0]   row_pos_m = '0;
    logic [ROW_W-1:0]   row_width_m = ROW_WIDTH_RESET;
    res_t               decoded [8];
    res_t               symbols_due [$];

    // stimulus side: which internal nodes hold a written entry
    bit                 node_known [256];
    logic [NODE_W-1:0]  loaded_nodes [$];
    bit                 gaps_on = 1'b1;
    int                 burst_left = 0;
    int                 ready_mode = 0;
    int                 ready_left = 0;

    int                 mismatches = 0;
    int                 words_taken = 0;
    int                 results_seen = 0;
    int                 row_ends_seen = 0;
    int                 cfg_writes = 0;
    int                 peak_burst = 0;

    huffman_tree_byte_decoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .node_index   (node_index),
        .left_child   (left_child),
        .right_child  (right_child),
        .symbol_count (symbol_count),
        .code_byte    (code_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .symbol       (symbol),
        .line_end     (line_end),
        .done_res     (done_res),
        .last         (last)
    );

    always #4 clk = ~clk;

    // Walk one accepted word through the tracked tree; symbol words land in
    // decoded[0..n-1]. Children 0 leave the walk where it is.
    function automatic int decode_word(input logic [REQ_W-1:0] op,
                                       input logic [NODE_W-1:0] node,
                                       input logic [NODE_W-1:0] left,
                                       input logic [NODE_W-1:0] right,
                                       input logic [COUNT_W-1:0] count,
                                       input logic [CODE_W-1:0] code);
        int n;
        int limit;
        logic [NODE_W-1:0] child;
        n = 0;
        case (op)
            REQ_LOAD:
                if (node > LEAF_TOP)
                begin
                    tree_left[node[7:0]]  = left;
                    tree_right[node[7:0]] = right;
                end
            REQ_START:
            begin
                syms_left_m = count;
                walk_node   = ROOT_NODE;
                row_pos_m   = '0;
            end
            REQ_BYTE:
                if (syms_left_m != 0)
                begin
                    limit = 2 * int'(row_width_m);
                    for (int i = CODE_W - 1; i >= 0; i--)
                    begin
                        child = code[i] ? tree_right[walk_node[7:0]]
                                        : tree_left[walk_node[7:0]];
                        if (child > LEAF_TOP)
                            walk_node = child;
                        else if (child != 0)
                        begin
                            // leaf: emit, return to the root
                            walk_node   = ROOT_NODE;
                            syms_left_m = syms_left_m - 1'b1;
                            row_pos_m   = row_pos_m + 1'b1;
                            decoded[n].symbol   = SYM_W'(child - 1'b1);
                            decoded[n].line_end = int'(row_pos_m) >= limit;
                            if (decoded[n].line_end)
                                row_pos_m = '0;
                            decoded[n].done_res = (syms_left_m == 0);
                            decoded[n].last     = 1'b0;
                            n++;
                            // count reached: drop the rest of the byte
                            if (syms_left_m == 0)
                                break;
                        end
                    end
                    if (n > 0)
                        decoded[n-1].last = 1'b1;
                end
            default: ;
        endcase
        return n;
    endfunction

    // Random junk in the payload fields; the builders below overwrite what matters.
    function automatic step_row_t blank_row(input logic [REQ_W-1:0] op);
        step_row_t w;
        w.is_cfg  = 1'b0;
        w.width   = '0;
        w.op      = op;
        w.node    = NODE_W'($urandom());
        w.left    = NODE_W'($urandom());
        w.right   = NODE_W'($urandom());
        w.count   = $urandom();
        w.code    = CODE_W'($urandom());
        w.typed   = 1'b0;
        w.n_typed = 0;
        w.want    = '0;
        return w;
    endfunction

    function automatic step_row_t load_row(input logic [NODE_W-1:0] node,
                                           input logic [NODE_W-1:0] left,
                                           input logic [NODE_W-1:0] right);
        step_row_t w;
        w       = blank_row(REQ_LOAD);
        w.node  = node;
        w.left  = left;
        w.right = right;
        return w;
    endfunction

    function automatic step_row_t start_row(input logic [COUNT_W-1:0] count);
        step_row_t w;
        w       = blank_row(REQ_START);
        w.count = count;
        return w;
    endfunction

    function automatic step_row_t byte_row(input logic [CODE_W-1:0] code);
        step_row_t w;
        w      = blank_row(REQ_BYTE);
        w.code = code;
        return w;
    endfunction

    function automatic step_row_t byte_row_typed(input logic [CODE_W-1:0] code,
                                                 input int n,
                                                 input logic [SYM_W-1:0] sym,
                                                 input logic le,
                                                 input logic done);
        step_row_t w;
        w         = byte_row(code);
        w.typed   = 1'b1;
        w.n_typed = n;
        w.want    = '{symbol: sym, line_end: le, done_res: done, last: 1'b1};
        return w;
    endfunction

    // request that must produce nothing
    function automatic step_row_t raw_row(input logic [REQ_W-1:0] op);
        step_row_t w;
        w       = blank_row(op);
        w.typed = 1'b1;
        return w;
    endfunction

    function automatic step_row_t cfg_row(input logic [ROW_W-1:0] width);
        step_row_t w;
        w        = blank_row(REQ_LOAD);
        w.is_cfg = 1'b1;
        w.width  = width;
        return w;
    endfunction

    // Child pointer that never leads the walk into an unwritten node:
    // a leaf, a node already written, no child at all, or the node itself.
    function automatic logic [NODE_W-1:0] pick_child(input logic [NODE_W-1:0] self_node);
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return NODE_W'($urandom_range(1, int'(LEAF_TOP)));
        if (r < 85 && loaded_nodes.size() > 0)
            return loaded_nodes[$urandom_range(0, loaded_nodes.size() - 1)];
        if (r < 93)
            return '0;
        return self_node;
    endfunction

    // Offer one word; with gaps on, the sender runs in bursts with random gaps between them.
    task automatic send_word(input step_row_t w);
        if (gaps_on && burst_left == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid     <= 1'b1;
        req_type     <= w.op;
        node_index   <= w.node;
        left_child   <= w.left;
        right_child  <= w.right;
        symbol_count <= w.count;
        code_byte    <= w.code;
        word_typed   <= w.typed;
        word_n_typed <= w.n_typed;
        word_want    <= w.want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        if (w.op == REQ_LOAD && w.node > LEAF_TOP && !node_known[w.node[7:0]])
        begin
            node_known[w.node[7:0]] = 1'b1;
            loaded_nodes.push_back(w.node);
        end
    endtask

    // Hold the sender until every predicted symbol word is out, then let a
    // walk that owes no result run to its end.
    task automatic drain_all();
        in_valid <= 1'b0;
        while (symbols_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_width(input logic [ROW_W-1:0] width);
        drain_all();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= width;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cfg_writes++;
    endtask

    // Receiver: switch among always-ready, coin-flip and mostly-stalled
    // stretches of random length.
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 2);
            ready_left = $urandom_range(20, 120);
        end
        else
            ready_left--;
        case (ready_mode)
            0:       out_ready <= 1'b1;
            1:       out_ready <= ($urandom_range(0, 1) == 1);
            default: out_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    // Predict on the input handshake, check on the output handshake. Both
    // live in one block so a same-edge push and pop keep their order.
    always @(posedge clk)
    begin : scoreboard
        int   n;
        res_t got;
        res_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                row_width_m = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                n = decode_word(req_type, node_index, left_child, right_child,
                                symbol_count, code_byte);
                words_taken++;
                if (n > peak_burst)
                    peak_burst = n;
                if (word_typed)
                begin
                    if (word_n_typed > 0)
                        symbols_due.push_back(word_want);
                end
                else
                begin
                    for (int i = 0; i < n; i++)
                        symbols_due.push_back(decoded[i]);
                end
            end
            if (out_valid && out_ready)
            begin
                got = '{symbol: symbol, line_end: line_end, done_res: done_res, last: last};
                results_seen++;
                if (line_end)
                    row_ends_seen++;
                if (symbols_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected word: sym=%02h le=%0b done=%0b last=%0b",
                                 got.symbol, got.line_end, got.done_res, got.last);
                end
                else
                begin
                    want = symbols_due.pop_front();
                    if (got.symbol !== want.symbol || got.line_end !== want.line_end ||
                        got.done_res !== want.done_res || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("word %0d: want %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                                     results_seen, want.symbol, want.line_end,
                                     want.done_res, want.last, got.symbol,
                                     got.line_end, got.done_res, got.last);
                    end
                end
            end
        end
    end

    initial
    begin : stimulus
        step_row_t        plan [DIRECTED_N];
        logic [ROW_W-1:0] width;
        int               k;
        int               pick;

        // Small tree: 00 -> 0x00, 01 -> 0xFF, 10 -> 0x41; on node 257 a
        // 1 bit has no child, so the walk parks there until a 0 arrives.
        plan = '{
            byte_row_typed(8'hA5, 0, 8'h00, 1'b0, 1'b0),     // nothing to decode yet
            raw_row(REQ_UNUSED),                             // unknown request
            load_row(LEAF_TOP, 9'd5, 9'd6),                  // leaf index: dropped
            load_row(9'd258, 9'd1, LEAF_TOP),
            load_row(9'd257, 9'd66, 9'd0),
            load_row(ROOT_NODE, 9'd258, 9'd257),
            start_row(32'd3),
            byte_row(8'h00),                                 // count hit mid-byte
            byte_row_typed(8'h00, 0, 8'h00, 1'b0, 1'b0),     // count used up
            start_row(32'hFFFF_FFFF),
            byte_row(8'h5F),                                 // ends parked on 257
            byte_row_typed(8'h7F, 1, 8'h41, 1'b0, 1'b0),
            start_row(32'd1),
            byte_row_typed(8'hBF, 1, 8'h41, 1'b0, 1'b1),
            cfg_row(12'd0),                                  // every symbol ends a row
            start_row(32'd2),
            byte_row_typed(8'hBF, 1, 8'h41, 1'b1, 1'b0),
            cfg_row(12'hFFF),
            start_row(32'h8000_0000),
            byte_row(8'h1B),
            load_row(ROOT_NODE, 9'd1, LEAF_TOP),             // one symbol per bit
            byte_row(8'h0F),                                 // eight symbols
            cfg_row(12'd1),
            start_row(32'd9),
            byte_row(8'h55),
            byte_row(8'hC3),
            load_row(ROOT_NODE, ROOT_NODE, LEAF_TOP),        // 0 loops on the root
            start_row(32'd4),
            byte_row_typed(8'h01, 1, 8'hFF, 1'b0, 1'b0),
            load_row(ROOT_NODE, 9'd258, 9'd257)
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                write_row_width(plan[i].width);
            else
                send_word(plan[i]);
        end

        for (int round_i = 0; round_i < RANDOM_ROUNDS; round_i++)
        begin
            gaps_on = ($urandom_range(0, 3) != 0);
            if (round_i % 4 == 0)
            begin
                case ($urandom_range(0, 5))
                    0:       width = '0;
                    1:       width = 12'd1;
                    2:       width = 12'hFFF;
                    3:       width = ROW_WIDTH_RESET;
                    4:       width = ROW_W'($urandom_range(2, 6));
                    default: width = ROW_W'($urandom());
                endcase
                write_row_width(width);
            end
            else if ($urandom_range(0, 2) == 0)
                drain_all();

            // rebuild part of the tree bottom-up, root last
            if (round_i == 0 || $urandom_range(0, 2) == 0)
            begin
                repeat ($urandom_range(1, 5))
                begin
                    k = $urandom_range(int'(LEAF_TOP) + 1, int'(ROOT_NODE) - 1);
                    send_word(load_row(NODE_W'(k), pick_child(NODE_W'(k)),
                                       pick_child(NODE_W'(k))));
                end
                send_word(load_row(ROOT_NODE, pick_child(ROOT_NODE),
                                   pick_child(ROOT_NODE)));
            end

            if ($urandom_range(0, 7) == 0)
                send_word(start_row($urandom()));
            else
                send_word(start_row($urandom_range(8, 64)));

            // mostly code bytes, sprinkled with noise and restarts
            repeat ($urandom_range(10, 20))
            begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    send_word(raw_row(REQ_UNUSED));
                else if (pick == 1)
                    send_word(load_row(NODE_W'($urandom_range(0, int'(LEAF_TOP))),
                                       NODE_W'($urandom()), NODE_W'($urandom())));
                else if (pick == 2)
                begin
                    k = $urandom_range(int'(LEAF_TOP) + 1, int'(ROOT_NODE));
                    send_word(load_row(NODE_W'(k), pick_child(NODE_W'(k)),
                                       pick_child(NODE_W'(k))));
                end
                else if (pick == 3)
                    send_word(start_row($urandom_range(0, 40)));
                else
                    send_word(byte_row(CODE_W'($urandom())));
            end
        end

        drain_all();
        $display("covered %0d input words, %0d symbols out, %0d row ends, up to %0d per byte",
                 words_taken, results_seen, row_ends_seen, peak_burst);
        $display("row width written %0d times, %0d mismatching words",
                 cfg_writes, mismatches);
        if (mismatches == 0 && symbols_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // watchdog: a hung handshake ends the run here
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
